[rtl/pixel_hit_stream_decoder_defines.svh]
// Assertion macros used by the checker file of the hit stream decoder.
`ifndef PIXEL_HIT_STREAM_DECODER_DEFINES_SVH
`define PIXEL_HIT_STREAM_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PHSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PHSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/phsd_pkg.sv]
package phsd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_HIT    = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERR    = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_BAD_HEADER  = 3'd0;
  localparam logic [2:0] ERR_BAD_START   = 3'd1;
  localparam logic [2:0] ERR_UNEXP_HEAD  = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN     = 3'd3;
  localparam logic [2:0] ERR_BAD_TRAILER = 3'd4;
  localparam logic [2:0] ERR_EARLY_END   = 3'd5;

  localparam logic [7:0] BYTE_HEAD = 8'hAA;
  localparam logic [7:0] BYTE_TAIL = 8'hBB;
  localparam logic [7:0] BYTE_IDLE = 8'hFF;

  // Picoseconds per tick.
  localparam logic [21:0] TICK_PS = 22'd12500;

  localparam int ADDR_W     = 19;
  localparam int OUT_DATA_W = 120;

  // One decoded command: a whole run of results for one input byte.
  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic [31:0]       trig;
    logic [63:0]       ts;
    logic [2:0]        err;
  } cmd_t;

endpackage

[rtl/phsd_front.sv]
module phsd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       byte_value,
  input  logic             last,
  output logic             push,
  output phsd_pkg::cmd_t   cmd
);

  localparam logic [3:0] PH_HEAD    = 4'd0;
  localparam logic [3:0] PH_TRIG    = 4'd1;
  localparam logic [3:0] PH_TICK    = 4'd2;
  localparam logic [3:0] PH_START   = 4'd3;
  localparam logic [3:0] PH_SKIP    = 4'd4;
  localparam logic [3:0] PH_CHIPID  = 4'd5;
  localparam logic [3:0] PH_BODY    = 4'd6;
  localparam logic [3:0] PH_SHORT2  = 4'd7;
  localparam logic [3:0] PH_LONG2   = 4'd8;
  localparam logic [3:0] PH_LONG3   = 4'd9;
  localparam logic [3:0] PH_PAD     = 4'd10;
  localparam logic [3:0] PH_TAIL    = 4'd11;
  localparam logic [3:0] PH_DISCARD = 4'd12;

  logic [3:0]  phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [1:0]  align_count, align_count_next;
  logic [4:0]  region, region_next;
  logic [5:0]  first_byte, first_byte_next;
  logic [7:0]  second_byte, second_byte_next;
  logic [31:0] trigger_reg, trigger_reg_next;
  logic [63:0] ts_reg, ts_reg_next;

  logic [3:0]  count_inc;
  logic [21:0] prod;
  logic [63:0] prod_shifted;
  logic        done;

  assign count_inc    = byte_count + 4'd1;
  assign prod         = {14'd0, byte_value} * phsd_pkg::TICK_PS;
  assign prod_shifted = {42'd0, prod} << {byte_count[2:0], 3'b000};

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    align_count_next = align_count;
    region_next      = region;
    first_byte_next  = first_byte;
    second_byte_next = second_byte;
    trigger_reg_next = trigger_reg;
    ts_reg_next      = ts_reg;
    done             = 1'b0;
    push             = 1'b0;
    cmd              = '0;

    if (accept) begin
      if (phase == PH_DISCARD) begin
        if (last) begin
          phase_next       = PH_HEAD;
          byte_count_next  = 4'd0;
          align_count_next = 2'd0;
        end
      end else begin
        unique case (phase)
          PH_HEAD: begin
            if (byte_value != phsd_pkg::BYTE_HEAD) begin
              push     = 1'b1;
              cmd.kind = phsd_pkg::KIND_ERR;
              cmd.err  = phsd_pkg::ERR_BAD_HEADER;
              done     = 1'b1;
            end else begin
              byte_count_next = count_inc;
              if (count_inc >= 4'd4) begin
                phase_next      = PH_TRIG;
                byte_count_next = 4'd0;
              end
            end
          end
          PH_TRIG: begin
            if (byte_count[1:0] == 2'd0) begin
              trigger_reg_next = '0;
            end
            trigger_reg_next[{byte_count[1:0], 3'b000} +: 8] = byte_value;
            byte_count_next = count_inc;
            if (count_inc >= 4'd4) begin
              phase_next      = PH_TICK;
              byte_count_next = 4'd0;
            end
          end
          PH_TICK: begin
            // The timestamp is built up byte by byte as a sum of scaled partial products.
            ts_reg_next = ((byte_count[2:0] == 3'd0) ? 64'd0 : ts_reg) + prod_shifted;
            byte_count_next = count_inc;
            if (count_inc >= 4'd8) begin
              phase_next      = PH_START;
              byte_count_next = 4'd0;
              push            = 1'b1;
              cmd.kind        = phsd_pkg::KIND_HEADER;
              cmd.trig        = trigger_reg;
              cmd.ts          = ts_reg_next;
            end
          end
          PH_START: begin
            if (byte_value[7:4] == 4'hE) begin
              phase_next      = PH_SKIP;
              byte_count_next = 4'd0;
            end else if (byte_value[7:4] == 4'hA) begin
              phase_next  = PH_CHIPID;
              region_next = 5'd0;
            end else begin
              push     = 1'b1;
              cmd.kind = phsd_pkg::KIND_ERR;
              cmd.err  = phsd_pkg::ERR_BAD_START;
              done     = 1'b1;
            end
          end
          PH_SKIP: begin
            byte_count_next = count_inc;
            if (count_inc >= 4'd3) begin
              phase_next      = PH_TAIL;
              byte_count_next = 4'd0;
            end
          end
          PH_CHIPID: begin
            phase_next = PH_BODY;
          end
          PH_BODY: begin
            priority if (byte_value[7:6] == 2'b00) begin
              first_byte_next = byte_value[5:0];
              phase_next      = PH_LONG2;
            end else if (byte_value[7:6] == 2'b01) begin
              first_byte_next = byte_value[5:0];
              phase_next      = PH_SHORT2;
            end else if (byte_value[7:5] == 3'b110) begin
              region_next = byte_value[4:0];
            end else if (byte_value[7:4] == 4'hB) begin
              // Chip trailer: pad up to the next 4-byte boundary of the block.
              if (align_count == 2'd3) begin
                phase_next      = PH_TAIL;
                byte_count_next = 4'd0;
              end else begin
                phase_next = PH_PAD;
              end
            end else if (byte_value == phsd_pkg::BYTE_IDLE) begin
              phase_next = PH_BODY;
            end else if (byte_value == phsd_pkg::BYTE_HEAD) begin
              push     = 1'b1;
              cmd.kind = phsd_pkg::KIND_ERR;
              cmd.err  = phsd_pkg::ERR_UNEXP_HEAD;
              done     = 1'b1;
            end else begin
              push     = 1'b1;
              cmd.kind = phsd_pkg::KIND_ERR;
              cmd.err  = phsd_pkg::ERR_UNKNOWN;
              done     = 1'b1;
            end
          end
          PH_SHORT2: begin
            push       = 1'b1;
            cmd.kind   = phsd_pkg::KIND_HIT;
            cmd.addr   = {region, first_byte, byte_value};
            cmd.trig   = trigger_reg;
            cmd.ts     = ts_reg;
            phase_next = PH_BODY;
          end
          PH_LONG2: begin
            second_byte_next = byte_value;
            phase_next       = PH_LONG3;
          end
          PH_LONG3: begin
            push       = 1'b1;
            cmd.kind   = phsd_pkg::KIND_HIT;
            cmd.addr   = {region, first_byte, second_byte};
            cmd.mask   = byte_value;
            cmd.trig   = trigger_reg;
            cmd.ts     = ts_reg;
            phase_next = PH_BODY;
          end
          PH_PAD: begin
            if (align_count == 2'd3) begin
              phase_next      = PH_TAIL;
              byte_count_next = 4'd0;
            end
          end
          PH_TAIL: begin
            if (byte_value != phsd_pkg::BYTE_TAIL) begin
              push     = 1'b1;
              cmd.kind = phsd_pkg::KIND_ERR;
              cmd.err  = phsd_pkg::ERR_BAD_TRAILER;
              done     = 1'b1;
            end else begin
              byte_count_next = count_inc;
              if (count_inc >= 4'd4) begin
                push     = 1'b1;
                cmd.kind = phsd_pkg::KIND_END;
                cmd.trig = trigger_reg;
                cmd.ts   = ts_reg;
                done     = 1'b1;
              end
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase

        align_count_next = align_count + 2'd1;

        // A last byte that does not close the block replaces whatever it produced.
        if (last && !done) begin
          push     = 1'b1;
          cmd      = '0;
          cmd.kind = phsd_pkg::KIND_ERR;
          cmd.err  = phsd_pkg::ERR_EARLY_END;
        end

        if (last) begin
          phase_next       = PH_HEAD;
          byte_count_next  = 4'd0;
          align_count_next = 2'd0;
        end else if (done) begin
          phase_next = PH_DISCARD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEAD;
      byte_count  <= 4'd0;
      align_count <= 2'd0;
      region      <= 5'd0;
      first_byte  <= 6'd0;
      second_byte <= 8'd0;
      trigger_reg <= 32'd0;
      ts_reg      <= 64'd0;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      align_count <= align_count_next;
      region      <= region_next;
      first_byte  <= first_byte_next;
      second_byte <= second_byte_next;
      trigger_reg <= trigger_reg_next;
      ts_reg      <= ts_reg_next;
    end
  end

endmodule

[rtl/phsd_queue.sv]
module phsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  phsd_pkg::cmd_t push_data,
  input  logic           pop,
  output phsd_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  phsd_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/phsd_back.sv]
module phsd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  phsd_pkg::cmd_t                    q_data,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [phsd_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [1:0]                        m_tuser,
  output logic                              m_tlast
);

  phsd_pkg::cmd_t            cur;
  logic                      cur_valid;
  logic                      first_pending;
  logic [7:0]                rem;

  logic                      out_free;
  logic                      step;
  logic [2:0]                bit_idx;
  logic [7:0]                rem_after;
  logic [phsd_pkg::ADDR_W-1:0] hit_addr;
  logic                      res_last;
  logic [9:0]                column;
  logic [8:0]                row;
  logic [31:0]               trig;
  logic [63:0]               ts;

  assign out_free = !m_tvalid || m_tready;
  assign step     = cur_valid && out_free;

  // Lowest set bit of the remaining long-word hit mask.
  always_comb begin
    bit_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rem[i]) begin
        bit_idx = 3'(i);
      end
    end
  end

  always_comb begin
    rem_after = rem;
    if (!first_pending) begin
      rem_after[bit_idx] = 1'b0;
    end
    hit_addr = first_pending ? cur.addr
                             : cur.addr + phsd_pkg::ADDR_W'(bit_idx) + 1'b1;
    res_last = (cur.kind != phsd_pkg::KIND_HIT) || (rem_after == 8'd0);
    if (cur.kind == phsd_pkg::KIND_HIT) begin
      column = {hit_addr[18:10], hit_addr[0] ^ hit_addr[1]};
      row    = hit_addr[9:1];
    end else begin
      column = 10'd0;
      row    = 9'd0;
    end
    trig = cur.trig;
    ts   = cur.ts;
  end

  assign q_pop = !q_empty && (!cur_valid || (step && res_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid     <= 1'b0;
      first_pending <= 1'b0;
      rem           <= 8'd0;
    end else begin
      if (q_pop) begin
        cur_valid     <= 1'b1;
        first_pending <= 1'b1;
        rem           <= q_data.mask;
      end else if (step) begin
        first_pending <= 1'b0;
        rem           <= rem_after;
        if (res_last) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {2'b00, cur.err, ts, trig, row, column};
      m_tuser <= cur.kind;
      m_tlast <= res_last;
    end
  end

endmodule

[rtl/pixel_hit_stream_decoder.sv]
// Pixel hit stream decoder.
// The input channel (s_tvalid, s_tready, s_tdata, s_tlast) takes one raw byte of a readout
// block per item; s_tlast marks the final byte of the block. The output channel (m_tvalid,
// m_tready, m_tdata, m_tuser, m_tlast) delivers result items: pixel hits, one event header,
// and a good end or an error per block. m_tuser holds the result kind and m_tlast marks the
// last result caused by one input byte.
// Throughput is one input byte per cycle while the queue is not full and one result per
// cycle while m_tready is high. A long hit word can give up to nine results for three bytes;
// a queue of QUEUE_DEPTH decoded commands between the byte parser and the result expander
// absorbs such bursts, and the input stalls only when that queue is full.
// A result passes from the queue through the expander's command register and then the
// output register before it is valid on the output. The expander, one result per cycle
// while the receiver takes them, sets the rate of the output side.
// Reset is synchronous and puts the parser in hunt for the block header, empties the queue
// and drops any pending result. When the receiver holds m_tready low, the output register
// keeps its item, the expander and then the queue fill, and s_tready drops once the queue
// is full; no item is lost.
module pixel_hit_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] byte_value
  input  logic                            s_tlast,  // last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [9:0] column, [18:10] row, [50:19] trigger_id, [114:51] timestamp,
  // [117:115] error_code, [119:118] zero fill
  output logic [phsd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]                      m_tuser,  // [1:0] kind
  output logic                            m_tlast   // run_end
);

  logic           accept;
  logic           push;
  phsd_pkg::cmd_t push_cmd;
  logic           pop;
  phsd_pkg::cmd_t pop_cmd;
  logic           q_full;
  logic           q_empty;

  // The parser may produce a command on any byte, so it waits whenever the queue is full.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Byte parser: tracks the block layout and turns each byte into at most one command.
  phsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (s_tdata),
    .last       (s_tlast),
    .push       (push),
    .cmd        (push_cmd)
  );

  phsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Result expander: turns each command into its run of result items.
  phsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (pop_cmd),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/phsd_checker.sv]
`include "pixel_hit_stream_decoder_defines.svh"

module phsd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [7:0]                      s_tdata,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [phsd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                      m_tuser,
  input logic                            m_tlast
);

  logic in_item;
  logic out_item;

  assign in_item  = s_tvalid && s_tready;
  assign out_item = m_tvalid;

  // A stalled result is held unchanged.
  `PHSD_ASSERT_NEXT(a_out_hold, out_item && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")

  // Header, end and error results stand alone, so each closes its run.
  `PHSD_ASSERT_SAME(a_single_run, out_item && (m_tuser != phsd_pkg::KIND_HIT), m_tlast, "non-hit result without run end")

  // Errors carry only their code, and the code is one of the defined ones.
  `PHSD_ASSERT_SAME(a_err_fields, out_item && (m_tuser == phsd_pkg::KIND_ERR), (m_tdata[114:0] == '0) && (m_tdata[117:115] <= phsd_pkg::ERR_EARLY_END), "error result with stray fields")

  // Only hits carry coordinates, and only errors carry a code.
  `PHSD_ASSERT_SAME(a_kind_fields, out_item && (m_tuser != phsd_pkg::KIND_ERR), (m_tdata[117:115] == '0) && ((m_tuser == phsd_pkg::KIND_HIT) || (m_tdata[18:0] == '0)), "result fields do not match kind")

  // Input accepts are not checked here beyond being well formed.
  `PHSD_ASSERT_SAME(a_in_known, in_item, !$isunknown({s_tdata, s_tlast}), "input item unknown")

endmodule

bind pixel_hit_stream_decoder phsd_checker u_phsd_checker (.*);
